FILE: src/satq_pkg.sv
// ----------------------------------------------------------------------------
// satq_pkg
// Shared types, sizes and helpers for the summed-area table query core.
// ----------------------------------------------------------------------------
package satq_pkg;

	localparam int MAX_ROWS    = 64;
	localparam int MAX_COLS    = 64;
	localparam int TABLE_DEPTH = MAX_ROWS * MAX_COLS;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int ROW_W       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int COL_W       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

	localparam int SIZE_W  = 7;   // size registers and bound fields
	localparam int VALUE_W = 16;
	localparam int ENTRY_W = 29;  // stored prefix sum
	localparam int SUM_W   = 28;

	localparam int NUM_CORNERS = 4;
	localparam int CNT_W       = $clog2(NUM_CORNERS + 1);

	localparam logic [SIZE_W-1:0] MAX_ROWS_V = SIZE_W'(MAX_ROWS);
	localparam logic [SIZE_W-1:0] MAX_COLS_V = SIZE_W'(MAX_COLS);

	// register indexes of the configuration port
	localparam logic REG_NUM_ROWS = 1'b0;
	localparam logic REG_NUM_COLS = 1'b1;

	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_BAD = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LD_RD,
		ST_LD_WR,
		ST_Q_RD,
		ST_Q_OUT
	} satq_state_t;

	// saturate a size register to 1..maxv
	function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
		input logic [SIZE_W-1:0] maxv);
		logic [SIZE_W-1:0] res;
		if (v == '0) begin
			res = SIZE_W'(1);
		end else if (v > maxv) begin
			res = maxv;
		end else begin
			res = v;
		end
		return res;
	endfunction

	// 0-based (row, col) to table address
	function automatic logic [ADDR_W-1:0] table_addr(input logic [ROW_W-1:0] row,
		input logic [COL_W-1:0] col);
		return ADDR_W'(int'(row) * MAX_COLS + int'(col));
	endfunction

endpackage

FILE: src/satq_ram.sv
// ----------------------------------------------------------------------------
// satq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module satq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: src/summed_area_table_query_core.sv
// ----------------------------------------------------------------------------
// summed_area_table_query_core
// Builds a 2D summed-area table from a row-major element stream and answers
// inclusive rectangle-sum queries from it.
// ----------------------------------------------------------------------------
// One item is processed at a time; in_ready is high only while the sequencer
// is idle. All work goes through a single prefix memory (one write, one
// registered read per cycle) and one shared 29-bit adder. A load reads the
// entry above, then writes the new prefix sum. A query issues four corner
// reads back to back and folds them into one accumulator, then places the
// result in the output register once any previous result has been taken.
// A bad query skips the reads and answers status 1 with sum 0. Loads may be
// accepted while a result waits on the output. Writing either size register
// restarts the load at the first element and invalidates the table.
// The memory is not cleared after reset.
// ----------------------------------------------------------------------------
module summed_area_table_query_core
	import satq_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [SIZE_W-1:0]         cfg_data,
	// input channel
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      func,
	input  logic signed [VALUE_W-1:0] value,
	input  logic [SIZE_W-1:0]         top_row,
	input  logic [SIZE_W-1:0]         bottom_row,
	input  logic [SIZE_W-1:0]         left_col,
	input  logic [SIZE_W-1:0]         right_col,
	// output channel
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [SUM_W-1:0]   rect_sum,
	output logic                      status
);

	satq_state_t state_q, state_d;

	logic [SIZE_W-1:0]         num_rows_q, num_cols_q;
	logic [SIZE_W-1:0]         rows, cols;
	logic [SIZE_W-1:0]         load_row_q, load_col_q;
	logic signed [ENTRY_W-1:0] run_q;
	logic                      loaded_q;
	logic signed [VALUE_W-1:0] elem_q;

	logic [SIZE_W-1:0]         top_q, bot_q, left_q, right_q;
	logic                      bad_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      zero_s1, sub_s1;
	logic signed [ENTRY_W-1:0] acc_q;

	logic                      out_valid_q;
	logic signed [SUM_W-1:0]   rect_sum_q;
	logic                      status_q;

	logic                      in_fire, out_free, restart_at_load, query_bad;
	logic [SIZE_W-1:0]         corner_row, corner_col;
	logic                      corner_zero, corner_sub;
	logic signed [ENTRY_W-1:0] above, corner_val, new_entry;
	logic signed [ENTRY_W-1:0] alu_a, alu_b, alu_sum;
	logic                      alu_sub;
	logic [SIZE_W-1:0]         col_next, row_next;

	logic                      ram_we;
	logic [ADDR_W-1:0]         ram_waddr, ram_raddr;
	logic [ENTRY_W-1:0]        ram_rdata;

	satq_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(new_entry),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rows     = clamp_size(num_rows_q, MAX_ROWS_V);
	assign cols     = clamp_size(num_cols_q, MAX_COLS_V);
	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	assign restart_at_load = loaded_q || (load_row_q >= rows) || (load_col_q >= cols);

	assign query_bad = !loaded_q || (top_row == '0) || (left_col == '0) ||
		(top_row > bottom_row) || (left_col > right_col) ||
		(bottom_row > rows) || (right_col > cols);

	// corner order: (b,r) add, (t-1,r) sub, (b,l-1) sub, (t-1,l-1) add
	always_comb begin
		corner_row  = (cnt_q[0] == 1'b0) ? bot_q : top_q - SIZE_W'(1);
		corner_col  = (cnt_q[1] == 1'b0) ? right_q : left_q - SIZE_W'(1);
		corner_zero = (corner_row == '0) || (corner_col == '0);
		corner_sub  = cnt_q[0] ^ cnt_q[1];
	end

	assign above      = (load_row_q != '0) ? $signed(ram_rdata) : '0;
	assign corner_val = zero_s1 ? '0 : $signed(ram_rdata);
	assign col_next   = load_col_q + SIZE_W'(1);
	assign row_next   = load_row_q + SIZE_W'(1);

	// shared adder: row sum on a load read, prefix entry on a load write,
	// corner fold during a query
	always_comb begin
		alu_a   = acc_q;
		alu_b   = corner_val;
		alu_sub = sub_s1;
		case (state_q)
			ST_LD_RD: begin
				alu_a   = run_q;
				alu_b   = ENTRY_W'(elem_q);
				alu_sub = 1'b0;
			end
			ST_LD_WR: begin
				alu_a   = above;
				alu_b   = run_q;
				alu_sub = 1'b0;
			end
			default: ;
		endcase
		alu_sum = alu_a + (alu_b ^ {ENTRY_W{alu_sub}}) + ENTRY_W'(alu_sub);
	end

	assign new_entry = alu_sum;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (func == FUNC_LOAD) begin
						state_d = ST_LD_RD;
					end else if (query_bad) begin
						state_d = ST_Q_OUT;
					end else begin
						state_d = ST_Q_RD;
					end
				end
			end
			ST_LD_RD: state_d = ST_LD_WR;
			ST_LD_WR: state_d = ST_IDLE;
			ST_Q_RD: begin
				if (cnt_q == CNT_W'(NUM_CORNERS)) begin
					state_d = ST_Q_OUT;
				end
			end
			ST_Q_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = table_addr(load_row_q[ROW_W-1:0], load_col_q[COL_W-1:0]);
		ram_raddr = table_addr(corner_row[ROW_W-1:0] - ROW_W'(1),
			corner_col[COL_W-1:0] - COL_W'(1));
		case (state_q)
			ST_IDLE:  in_ready = 1'b1;
			ST_LD_RD: ram_raddr = table_addr(load_row_q[ROW_W-1:0] - ROW_W'(1),
				load_col_q[COL_W-1:0]);
			ST_LD_WR: ram_we = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			num_rows_q  <= MAX_ROWS_V;
			num_cols_q  <= MAX_COLS_V;
			load_row_q  <= '0;
			load_col_q  <= '0;
			run_q       <= '0;
			loaded_q    <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_we) begin
				if (cfg_index == REG_NUM_ROWS) begin
					num_rows_q <= cfg_data;
				end else begin
					num_cols_q <= cfg_data;
				end
				load_row_q <= '0;
				load_col_q <= '0;
				run_q      <= '0;
				loaded_q   <= 1'b0;
			end

			if (in_fire && func == FUNC_LOAD && restart_at_load) begin
				load_row_q <= '0;
				load_col_q <= '0;
				run_q      <= '0;
				loaded_q   <= 1'b0;
			end

			if (state_q == ST_LD_RD) begin
				run_q <= alu_sum;
			end

			// advance the load position after the write
			if (state_q == ST_LD_WR) begin
				if (col_next >= cols) begin
					load_col_q <= '0;
					run_q      <= '0;
					if (row_next >= rows) begin
						load_row_q <= '0;
						loaded_q   <= 1'b1;
					end else begin
						load_row_q <= row_next;
					end
				end else begin
					load_col_q <= col_next;
				end
			end

			if (in_fire) begin
				cnt_q <= '0;
			end else if (state_q == ST_Q_RD) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end

			if (state_q == ST_Q_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			elem_q  <= value;
			top_q   <= top_row;
			bot_q   <= bottom_row;
			left_q  <= left_col;
			right_q <= right_col;
			bad_q   <= query_bad;
			acc_q   <= '0;
		end
		if (state_q == ST_Q_RD) begin
			zero_s1 <= corner_zero;
			sub_s1  <= corner_sub;
			// fold the corner read in the previous cycle
			if (cnt_q != '0) begin
				acc_q <= alu_sum;
			end
		end
		if (state_q == ST_Q_OUT && out_free) begin
			rect_sum_q <= bad_q ? '0 : acc_q[SUM_W-1:0];
			status_q   <= bad_q ? STATUS_BAD : STATUS_OK;
		end
	end

	assign out_valid = out_valid_q;
	assign rect_sum  = rect_sum_q;
	assign status    = status_q;

endmodule

FILE: sim/summed_area_table_query_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// summed_area_table_query_core_tb
// Streams matrices into the core and fires rectangle-sum queries at them.
// Every answer is compared with a cycle-free predictor of the prefix table,
// under random idle on the input and backpressure on the output, and several sizes.
// ----------------------------------------------------------------------------
module summed_area_table_query_core_tb;
	import satq_pkg::*;

	localparam int SETTLE_CYCLES = 8;
	localparam int QUIET_LIMIT   = 2000;
	localparam int PHASES        = 8;
	localparam int PHASE_BUDGET  = 40;

	typedef struct packed {
		logic                      func;
		logic signed [VALUE_W-1:0] value;
		logic [SIZE_W-1:0]         t_row;
		logic [SIZE_W-1:0]         b_row;
		logic [SIZE_W-1:0]         l_col;
		logic [SIZE_W-1:0]         r_col;
	} sat_item_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] sum;
		logic                    status;
	} sat_result_t;

	typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

	typedef struct packed {
		row_kind_t         kind;
		sat_item_t         item;
		logic              reg_idx;
		logic [SIZE_W-1:0] reg_val;
		logic              typed;
		sat_result_t       res;
	} plan_row_t;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_we;
	logic                      cfg_index;
	logic [SIZE_W-1:0]         cfg_data;
	logic                      in_valid;
	logic                      in_ready;
	logic                      func;
	logic signed [VALUE_W-1:0] value;
	logic [SIZE_W-1:0]         top_row;
	logic [SIZE_W-1:0]         bottom_row;
	logic [SIZE_W-1:0]         left_col;
	logic [SIZE_W-1:0]         right_col;
	logic                      out_valid;
	logic                      out_ready;
	logic signed [SUM_W-1:0]   rect_sum;
	logic                      status;

	// predicted table and load position
	logic signed [ENTRY_W-1:0] prefix_mem [TABLE_DEPTH];
	int                        fill_row;
	int                        fill_col;
	logic signed [ENTRY_W-1:0] fill_row_sum;
	bit                        table_full;
	logic [SIZE_W-1:0]         rows_reg;
	logic [SIZE_W-1:0]         cols_reg;

	sat_result_t pending_sums [$];
	plan_row_t   plan [$];
	sat_result_t want_res;
	int          mismatches    = 0;
	int          quiet_cycles  = 0;
	int          send_idle_pct = 0;
	int          stall_pct     = 0;

	int phase_rows [PHASES]  = '{1, 127, 0, 5, 65, 8, 3, 6};
	int phase_cols [PHASES]  = '{1, 0, 64, 7, 2, 8, 12, 5};
	int idle_by_mode [4]     = '{0, 47, 0, 10};
	int stall_by_mode [4]    = '{0, 0, 47, 10};

	summed_area_table_query_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.value     (value),
		.top_row   (top_row),
		.bottom_row(bottom_row),
		.left_col  (left_col),
		.right_col (right_col),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.rect_sum  (rect_sum),
		.status    (status)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int eff_size(input logic [SIZE_W-1:0] v, input int maxv);
		if (v == '0) return 1;
		if (int'(v) > maxv) return maxv;
		return int'(v);
	endfunction

	function automatic void restart_fill();
		fill_row     = 0;
		fill_col     = 0;
		fill_row_sum = '0;
		table_full   = 1'b0;
	endfunction

	// prefix sum at 1-based (r, c), zero on the border
	function automatic int corner_sum(input int r, input int c);
		if (r == 0 || c == 0) return 0;
		return int'(prefix_mem[(r - 1) * MAX_COLS + (c - 1)]);
	endfunction

	function automatic void predict_item(input sat_item_t it, output bit has_res,
		output sat_result_t res);
		int rows;
		int cols;
		int above;
		int t;
		int b;
		int l;
		int r;
		int s;
		rows    = eff_size(rows_reg, MAX_ROWS);
		cols    = eff_size(cols_reg, MAX_COLS);
		has_res = 1'b0;
		res     = '0;
		if (it.func == FUNC_LOAD) begin
			if (table_full) restart_fill();
			if (fill_row >= rows || fill_col >= cols) restart_fill();
			above = (fill_row > 0) ?
				int'(prefix_mem[(fill_row - 1) * MAX_COLS + fill_col]) : 0;
			fill_row_sum = fill_row_sum + $signed(it.value);
			prefix_mem[fill_row * MAX_COLS + fill_col] =
				ENTRY_W'(above + int'(fill_row_sum));
			fill_col++;
			if (fill_col >= cols) begin
				fill_col     = 0;
				fill_row_sum = '0;
				fill_row++;
				if (fill_row >= rows) begin
					fill_row   = 0;
					table_full = 1'b1;
				end
			end
		end else begin
			t       = int'(it.t_row);
			b       = int'(it.b_row);
			l       = int'(it.l_col);
			r       = int'(it.r_col);
			has_res = 1'b1;
			if (!table_full || t < 1 || l < 1 || t > b || l > r || b > rows || r > cols) begin
				res.sum    = '0;
				res.status = STATUS_BAD;
			end else begin
				s = corner_sum(b, r) - corner_sum(t - 1, r) - corner_sum(b, l - 1) +
					corner_sum(t - 1, l - 1);
				res.sum    = SUM_W'(s);
				res.status = STATUS_OK;
			end
		end
	endfunction

	function automatic sat_item_t rand_query(input int rows, input int cols, input bit noise);
		sat_item_t q;
		q.func  = FUNC_QUERY;
		q.value = VALUE_W'($urandom);
		if (noise) begin
			q.t_row = SIZE_W'($urandom_range(0, 127));
			q.b_row = SIZE_W'($urandom_range(0, 127));
			q.l_col = SIZE_W'($urandom_range(0, 127));
			q.r_col = SIZE_W'($urandom_range(0, 127));
		end else begin
			q.t_row = SIZE_W'($urandom_range(1, rows));
			q.b_row = SIZE_W'($urandom_range(q.t_row, rows));
			q.l_col = SIZE_W'($urandom_range(1, cols));
			q.r_col = SIZE_W'($urandom_range(q.l_col, cols));
		end
		return q;
	endfunction

	function automatic void add_load(input logic signed [VALUE_W-1:0] v);
		plan_row_t row;
		row            = '0;
		row.kind       = ROW_ITEM;
		row.item.func  = FUNC_LOAD;
		row.item.value = v;
		plan.push_back(row);
	endfunction

	function automatic void add_checked(input int t, input int b, input int l, input int r,
		input logic signed [SUM_W-1:0] sum, input logic st);
		plan_row_t row;
		row            = '0;
		row.kind       = ROW_ITEM;
		row.item.func  = FUNC_QUERY;
		row.item.t_row = SIZE_W'(t);
		row.item.b_row = SIZE_W'(b);
		row.item.l_col = SIZE_W'(l);
		row.item.r_col = SIZE_W'(r);
		row.typed      = 1'b1;
		row.res.sum    = sum;
		row.res.status = st;
		plan.push_back(row);
	endfunction

	function automatic void add_query(input int t, input int b, input int l, input int r);
		add_checked(t, b, l, r, '0, STATUS_OK);
		plan[plan.size() - 1].typed = 1'b0;
	endfunction

	function automatic void add_write(input logic idx, input logic [SIZE_W-1:0] v);
		plan_row_t row;
		row         = '0;
		row.kind    = ROW_WRITE;
		row.reg_idx = idx;
		row.reg_val = v;
		plan.push_back(row);
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("%0t mismatch: %s", $time, what);
	endtask

	task automatic send_item(input sat_item_t it, input logic typed,
		input sat_result_t typed_res);
		bit          has_res;
		sat_result_t res;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		func       <= it.func;
		value      <= it.value;
		top_row    <= it.t_row;
		bottom_row <= it.b_row;
		left_col   <= it.l_col;
		right_col  <= it.r_col;
		@(posedge clk);
		while (in_ready !== 1'b1) @(posedge clk);
		predict_item(it, has_res, res);
		if (has_res) pending_sums.push_back(typed ? typed_res : res);
	endtask

	// write only with the core drained; a load leaves no result to wait for
	task automatic write_size(input logic idx, input logic [SIZE_W-1:0] v);
		in_valid <= 1'b0;
		while (pending_sums.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_NUM_ROWS) rows_reg = v;
		else cols_reg = v;
		restart_fill();
	endtask

	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= stall_pct);
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (arst_n && out_valid && out_ready) begin
			if (pending_sums.size() == 0) begin
				report_mismatch($sformatf("result sum=%0d status=%0b with no query pending",
					rect_sum, status));
			end else begin
				want_res = pending_sums.pop_front();
				if (rect_sum !== want_res.sum)
					report_mismatch($sformatf("rect_sum %0d, want %0d", rect_sum,
						$signed(want_res.sum)));
				if (status !== want_res.status)
					report_mismatch($sformatf("status %0b, want %0b", status,
						want_res.status));
			end
		end
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("[summed_area_table_query_core] ERROR");
		$finish;
	end

	initial begin
		int        rows_now;
		int        cols_now;
		int        n_cells;
		int        issued;
		int        need;
		int        cnt;
		sat_item_t it;

		arst_n     <= 1'b0;
		cfg_we     <= 1'b0;
		cfg_index  <= REG_NUM_ROWS;
		cfg_data   <= '0;
		in_valid   <= 1'b0;
		func       <= FUNC_LOAD;
		value      <= '0;
		top_row    <= '0;
		bottom_row <= '0;
		left_col   <= '0;
		right_col  <= '0;
		out_ready  <= 1'b0;

		rows_reg = MAX_ROWS_V;
		cols_reg = MAX_COLS_V;
		restart_fill();
		foreach (prefix_mem[i]) prefix_mem[i] = '0;

		add_checked(1, 1, 1, 1, '0, STATUS_BAD);  // nothing loaded since reset
		add_write(REG_NUM_ROWS, 7'd0);            // zero acts as one row
		add_write(REG_NUM_COLS, 7'd2);
		add_load(16'sh7FFF);
		add_checked(1, 1, 1, 1, '0, STATUS_BAD);  // half loaded
		add_load(16'sh8000);
		add_checked(1, 1, 1, 1, 28'sd32767, STATUS_OK);
		add_checked(1, 1, 1, 2, -28'sd1, STATUS_OK);
		add_checked(1, 1, 1, 3, '0, STATUS_BAD);
		add_checked(0, 1, 1, 1, '0, STATUS_BAD);
		add_checked(1, 1, 0, 1, '0, STATUS_BAD);
		add_checked(2, 1, 1, 1, '0, STATUS_BAD);
		add_checked(1, 1, 2, 1, '0, STATUS_BAD);
		add_checked(1, 2, 1, 1, '0, STATUS_BAD);
		add_load(16'sd5);                         // table full: start a new one
		add_checked(1, 1, 1, 1, '0, STATUS_BAD);
		add_load(-16'sd7);
		add_query(1, 1, 2, 2);
		add_write(REG_NUM_COLS, 7'd2);            // same value still drops the table
		add_checked(1, 1, 1, 2, '0, STATUS_BAD);
		add_write(REG_NUM_ROWS, 7'd2);
		add_load(16'sd100);
		add_load(-16'sd200);
		add_load(16'sd300);
		add_load(-16'sd400);
		add_query(2, 2, 2, 2);
		add_query(1, 2, 1, 2);
		add_checked(127, 127, 127, 127, '0, STATUS_BAD);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_WRITE) write_size(plan[i].reg_idx, plan[i].reg_val);
			else send_item(plan[i].item, plan[i].typed, plan[i].res);
		end

		for (int p = 0; p < PHASES; p++) begin
			write_size(REG_NUM_ROWS, SIZE_W'(phase_rows[p]));
			write_size(REG_NUM_COLS, SIZE_W'(phase_cols[p]));
			send_idle_pct = idle_by_mode[p % 4];
			stall_pct     = stall_by_mode[p % 4];
			rows_now      = eff_size(rows_reg, MAX_ROWS);
			cols_now      = eff_size(cols_reg, MAX_COLS);
			n_cells       = rows_now * cols_now;
			issued        = 0;
			while (issued < PHASE_BUDGET) begin
				// finish the table, now and then stop short of it
				need = table_full ? n_cells : n_cells - (fill_row * cols_now + fill_col);
				cnt  = ($urandom_range(0, 5) == 0) ? $urandom_range(1, need) : need;
				repeat (cnt) begin
					if ($urandom_range(0, 11) == 0) begin
						send_item(rand_query(rows_now, cols_now, 1'b1), 1'b0, '0);
						issued++;
					end
					it.func = FUNC_LOAD;
					case ($urandom_range(0, 7))
						0: begin
							it.value = 16'sh7FFF;
						end
						1: begin
							it.value = 16'sh8000;
						end
						default: begin
							it.value = VALUE_W'($urandom);
						end
					endcase
					it.t_row = SIZE_W'($urandom_range(0, 127));
					it.b_row = SIZE_W'($urandom_range(0, 127));
					it.l_col = SIZE_W'($urandom_range(0, 127));
					it.r_col = SIZE_W'($urandom_range(0, 127));
					send_item(it, 1'b0, '0);
					issued++;
				end
				repeat ($urandom_range(6, 12)) begin
					send_item(rand_query(rows_now, cols_now, $urandom_range(0, 4) == 0),
						1'b0, '0);
					issued++;
				end
			end
		end

		in_valid <= 1'b0;
		while (pending_sums.size() != 0) @(posedge clk);
		repeat (4 * SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("[summed_area_table_query_core] OK");
		end else begin
			$display("[summed_area_table_query_core] ERROR");
		end
		$finish;
	end

endmodule

FILE: summed_area_table_query_core.f
src/satq_pkg.sv
src/satq_ram.sv
src/summed_area_table_query_core.sv
sim/summed_area_table_query_core_tb.sv
